// ===== rtl/core/lap3_pkg.sv =====
`default_nettype none
package lap3_pkg;

  // Field and register widths
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;

  // Frame geometry limits
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

  // Arithmetic widths: column sum of three pixels, window total, signed response
  localparam int unsigned COL_SUM_W = 10;
  localparam int unsigned TOTAL_W   = 12;
  localparam int unsigned ACC_W     = 12;
  localparam logic [PIX_W-1:0] SAT_MAX = 8'd255;

  // Output queue
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OUT_CNT_W = 4;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: rows r-2, r-1, r
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-word control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic frame_last;
  } flags_t;

  typedef struct packed {
    logic frame_last;
    pix_t edge_value;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage
`default_nettype wire

// ===== rtl/core/lap3_ram.sv =====
`default_nettype none
module lap3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one port, read the other into a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lap3_cell.sv =====
`default_nettype none
module lap3_cell
  import lap3_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    shift_i,
  input  wire col_t              col_i,
  output col_t                   col_o,
  output logic [COL_SUM_W-1:0]   col_sum_o
);

  col_t col_q;

  // Take the neighbor's column on every shift
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  // Column sum feeds the window total
  assign col_sum_o = COL_SUM_W'(col_q.top) + COL_SUM_W'(col_q.mid) + COL_SUM_W'(col_q.bot);

endmodule
`default_nettype wire

// ===== rtl/core/lap3_out_fifo.sv =====
`default_nettype none
module lap3_out_fifo
  import lap3_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   wr_en_i,
  input  wire out_word_t        wr_data_i,
  input  wire                   rd_en_i,
  output logic                  rd_valid_o,
  output out_word_t             rd_data_o,
  output logic [OUT_CNT_W-1:0]  count_o
);

  out_word_t            mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic                 pop;

  assign pop = rd_en_i && (count_q != '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({wr_en_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

endmodule
`default_nettype wire

// ===== rtl/core/laplacian_edge_detect_3x3_top.sv =====
// Channel        | Dir | Signals                                  | Word
// ---------------+-----+------------------------------------------+------------------------------
// pixel in       | in  | s_axis_tvalid/tready/tdata               | tdata[7:0] pixel_in
// edge out       | out | m_axis_tvalid/tready/tdata/tlast         | tdata[7:0] edge_value,
//                |     |                                          | tlast frame_last
// config write   | in  | cfg_valid_i/ready_o/index_i/data_i       | 0 image_width, 1 image_height
//
// One pixel is accepted per cycle while input ready is high; a result passes the registered
// line-store read, the window cell chain and the registered response before it enters the output
// queue, and is offered at once when the queue is otherwise empty.
// Reset clears counters, pipeline valids and the output queue; line stores need no clearing.
// Input ready drops once the eight-word output queue plus words in flight are full.
// Configuration writes are taken in any cycle.
`default_nettype none
module laplacian_edge_detect_3x3_top
  import lap3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire [7:0]              s_axis_tdata,   // [7:0] pixel_in
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] edge_value
  output logic                   m_axis_tlast,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned MW_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W   = ((MW_W > WIDTH_REG_W) ? MW_W : WIDTH_REG_W) + 1;
  localparam int unsigned INFL_W  = OUT_CNT_W + 1;

  // Configuration registers
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamp geometry and find last column and row
  logic [CMP_W-1:0]        width_ext, width_eff, width_last;
  logic [HEIGHT_REG_W-1:0] height_eff, height_last;

  always_comb begin
    width_ext = CMP_W'(width_q);
    if (width_ext < CMP_W'(MIN_DIM)) begin
      width_eff = CMP_W'(MIN_DIM);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    width_last = width_eff - 1'b1;

    if (height_q < HEIGHT_REG_W'(MIN_DIM)) begin
      height_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
    height_last = height_eff - 1'b1;
  end

  // Raster position
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept, row_end, frame_end, emit;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign row_end   = CMP_W'(col_q) >= width_last;
  assign frame_end = row_end && (HEIGHT_REG_W'(row_q) >= height_last);
  assign emit      = (row_q >= ROW_W'(2)) && (CMP_W'(col_q) >= CMP_W'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: line-store read in flight
  logic             v1_q, v2_q, v3_q;
  pix_t             px1_q;
  logic [COL_W-1:0] idx1_q;
  flags_t           flags1_q, flags2_q, flags3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q    <= s_axis_tdata;
      idx1_q   <= col_q;
      flags1_q <= '{emit: emit, frame_last: frame_end};
    end
    flags2_q <= flags1_q;
    flags3_q <= flags2_q;
  end

  // Line stores: older row takes the newer row's old entry, newer takes the pixel
  pix_t older_rd, newer_rd;

  lap3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (idx1_q),
    .wdata_i (newer_rd),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  lap3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (idx1_q),
    .wdata_i (px1_q),
    .raddr_i (col_q),
    .rdata_o (newer_rd)
  );

  // Window: three column cells, newest column enters at the right
  col_t                 cell_in  [3];
  col_t                 cell_out [3];
  logic [COL_SUM_W-1:0] cell_sum [3];

  assign cell_in[2] = '{top: older_rd, mid: newer_rd, bot: px1_q};
  assign cell_in[1] = cell_out[2];
  assign cell_in[0] = cell_out[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    lap3_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (v1_q),
      .col_i     (cell_in[g]),
      .col_o     (cell_out[g]),
      .col_sum_o (cell_sum[g])
    );
  end

  // Stage 2: eight times centre minus neighbors, as nine times centre minus the total
  logic [TOTAL_W-1:0]      total, nine_centre;
  logic signed [ACC_W:0]   acc_wide;
  logic signed [ACC_W-1:0] acc3_q;

  assign total       = TOTAL_W'(cell_sum[0]) + TOTAL_W'(cell_sum[1]) + TOTAL_W'(cell_sum[2]);
  assign nine_centre = {1'b0, cell_out[1].mid, 3'b000} + TOTAL_W'(cell_out[1].mid);
  assign acc_wide    = $signed({1'b0, nine_centre}) - $signed({1'b0, total});

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc3_q <= acc_wide[ACC_W-1:0];
    end
  end

  // Stage 3: magnitude and saturation
  logic [ACC_W-1:0] mag;
  out_word_t        res_word;

  assign mag = acc3_q[ACC_W-1] ? ACC_W'(-acc3_q) : ACC_W'(acc3_q);
  assign res_word.edge_value = (mag > ACC_W'(SAT_MAX)) ? SAT_MAX : mag[PIX_W-1:0];
  assign res_word.frame_last = flags3_q.frame_last;

  // Output queue decouples the pipeline from the sink
  out_word_t            out_word;
  logic [OUT_CNT_W-1:0] out_count;
  logic [INFL_W-1:0]    occupancy;

  lap3_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (v3_q && flags3_q.emit),
    .wr_data_i  (res_word),
    .rd_en_i    (m_axis_tready),
    .rd_valid_o (m_axis_tvalid),
    .rd_data_o  (out_word),
    .count_o    (out_count)
  );

  // Hold off input when queued plus in-flight words could overflow the queue
  assign occupancy = INFL_W'(out_count) + INFL_W'(v1_q) + INFL_W'(v2_q) + INFL_W'(v3_q);
  assign s_axis_tready = occupancy < INFL_W'(OUT_DEPTH);

  assign m_axis_tdata = out_word.edge_value;
  assign m_axis_tlast = out_word.frame_last;

endmodule
`default_nettype wire

// ===== bench/laplacian_edge_checker.sv =====
`timescale 1ns / 100ps
module laplacian_edge_checker
  import lap3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  pix_valid_i,
  input  wire                  pix_ready_i,
  input  wire [PIX_W-1:0]      pix_data_i,     // [7:0] pixel_in
  input  wire                  edge_valid_i,
  input  wire                  edge_ready_i,
  input  wire [PIX_W-1:0]      edge_data_i,    // [7:0] edge_value
  input  wire                  edge_last_i,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  pix_t                    older_row [MAX_WIDTH];
  pix_t                    newer_row [MAX_WIDTH];
  pix_t                    win [3][3];   // [row][col], col 2 is the newest column
  int unsigned             col_cnt;
  int unsigned             row_cnt;
  int unsigned             errors;
  out_word_t               edges_due [$];
  out_word_t               edge_want;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Shift one pixel into the window and line stores; queue the edge word it completes
  task automatic laplacian_step(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    int unsigned i;
    int          acc;
    logic        row_end;
    logic        frame_end;
    out_word_t   word;
    w         = clamp_dim(width_reg, MAX_WIDTH);
    h         = clamp_dim(height_reg, MAX_HEIGHT);
    slot      = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
    row_end   = (col_cnt >= w - 1);
    frame_end = row_end && (row_cnt >= h - 1);

    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_row[slot];
    win[1][2] = newer_row[slot];
    win[2][2] = px;
    older_row[slot] = newer_row[slot];
    newer_row[slot] = px;

    if (row_cnt >= 2 && col_cnt >= 2) begin
      // eight times the center less its neighbors = nine times the center less all nine
      acc = 9 * int'(win[1][1]);
      for (i = 0; i < 9; i++) acc -= int'(win[i / 3][i % 3]);
      if (acc < 0) acc = -acc;
      if (acc > int'(SAT_MAX)) acc = int'(SAT_MAX);
      word.edge_value = pix_t'(acc);
      word.frame_last = frame_end;
      edges_due.push_back(word);
    end

    // Advance the raster position
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      win        = '{default: '0};
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
      edges_due.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Compare each accepted edge word with the oldest one due
      if (edge_valid_i && edge_ready_i) begin
        if (edges_due.size() == 0) begin
          $display("%0t: edge word with none due: expected none, actual value %0d last %0b",
                   $time, edge_data_i, edge_last_i);
          errors++;
        end else begin
          edge_want = edges_due.pop_front();
          if (edge_data_i !== edge_want.edge_value) begin
            $display("%0t: edge value mismatch: expected %0d, actual %0d",
                     $time, edge_want.edge_value, edge_data_i);
            errors++;
          end
          if (edge_last_i !== edge_want.frame_last) begin
            $display("%0t: frame last mismatch: expected %0b, actual %0b",
                     $time, edge_want.frame_last, edge_last_i);
            errors++;
          end
        end
      end

      if (pix_valid_i && pix_ready_i) laplacian_step(pix_data_i);

      // Track register writes; a pixel on the same edge still sees the old geometry
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_reg = cfg_data_i[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_data_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end

      errors_o  <= errors;
      pending_o <= edges_due.size();
    end
  end

endmodule

// ===== bench/laplacian_edge_detect_3x3_top_tb.sv =====
`timescale 1ns / 100ps
module laplacian_edge_detect_3x3_top_tb;
  import lap3_pkg::*;

  localparam int unsigned MAX_WIDTH     = 2048;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASE_PIXELS  = 290;
  localparam int unsigned LONG_ROW_PIX  = 40;

  typedef enum int unsigned {
    TEX_NOISE,
    TEX_BINARY,
    TEX_SMOOTH,
    TEX_RAMP
  } texture_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned edge_errors;
  int unsigned edges_pending;
  int unsigned cur_w;
  int unsigned cur_h;

  laplacian_edge_detect_3x3_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  laplacian_edge_checker #(
    .MAX_WIDTH(MAX_WIDTH)
  ) edge_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_i (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .edge_valid_i(m_axis_tvalid),
    .edge_ready_i(m_axis_tready),
    .edge_data_i (m_axis_tdata),
    .edge_last_i (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (edge_errors),
    .pending_o   (edges_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #1_000_000;
    $display("** laplacian_edge_detect_3x3_top: FAILED **");
    $finish;
  end

  // Stall the edge output at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one pixel word after a random gap; valid stays high on return
  task automatic push_pixel(input pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the pixel input until every due edge word is out and the pipeline is empty
  task automatic drain_edges();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (edges_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pix_t texture_pixel(input texture_e tex, input pix_t base,
                                         input int unsigned col, input int unsigned row);
    int v;
    case (tex)
      TEX_BINARY: v = ($urandom_range(1) != 0) ? 255 : 0;
      TEX_SMOOTH: v = int'(base) + int'($urandom_range(6)) - 3;
      TEX_RAMP:   v = (int'(base) + 5 * int'(col) + 3 * int'(row)) % 256;
      default:    v = $urandom_range(255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // Mostly short extents, sometimes below the minimum, sometimes a bit longer
  function automatic int unsigned pick_extent(input int unsigned common_hi,
                                              input int unsigned rare_hi);
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return $urandom_range(MIN_DIM - 1);
    if (roll == 1) return $urandom_range(rare_hi, common_hi + 1);
    return $urandom_range(common_hi, MIN_DIM);
  endfunction

  // Send one whole frame, with a full drain at a random spot now and then
  task automatic send_frame(input int unsigned w, input int unsigned h);
    texture_e    tex;
    pix_t        base;
    int unsigned r;
    int unsigned c;
    int unsigned pause_at;
    tex      = texture_e'($urandom_range(3));
    base     = pix_t'($urandom_range(255));
    pause_at = ($urandom_range(3) == 0) ? $urandom_range(w * h - 1) : w * h;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        if (r * w + c == pause_at) drain_edges();
        push_pixel(texture_pixel(tex, base, c, r));
      end
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned k;
    int unsigned w_raw;
    int unsigned h_raw;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_IMAGE_WIDTH;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_w          = MIN_DIM;
    cur_h          = MIN_DIM;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lone bright center on the smallest frame: positive saturation
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    for (k = 0; k < 9; k++) push_pixel((k == 4) ? 8'd255 : 8'd0);

    // Lone dark center, geometry below the minimum acting as the minimum
    drain_edges();
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    for (k = 0; k < 9; k++) push_pixel((k == 4) ? 8'd0 : 8'd255);

    // One count above a flat field: small unsaturated response
    drain_edges();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    for (k = 0; k < 9; k++) push_pixel((k == 4) ? 8'd129 : 8'd128);

    // Long row under oversize geometry, then shrink width and height mid-frame
    drain_edges();
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    for (k = 0; k < LONG_ROW_PIX; k++) push_pixel(pix_t'($urandom_range(255)));
    drain_edges();
    // column already past the new row end
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    for (k = 0; k < 15; k++) push_pixel(pix_t'($urandom_range(255)));
    drain_edges();
    // row already past the new frame end
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    for (k = 0; k < 2; k++) push_pixel(pix_t'($urandom_range(255)));
    cur_w = 4;
    cur_h = 3;

    // Random frames under each idling mix
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        if ($urandom_range(9) < 7) begin
          drain_edges();
          w_raw = pick_extent(16, 48);
          h_raw = pick_extent(6, 10);
          // bit 12 of a width word is not part of the register
          write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(1)), 12'(w_raw)});
          write_reg(REG_IMAGE_HEIGHT, 13'(h_raw));
          cur_w = (w_raw < MIN_DIM) ? MIN_DIM : w_raw;
          cur_h = (h_raw < MIN_DIM) ? MIN_DIM : h_raw;
        end
        send_frame(cur_w, cur_h);
        sent += cur_w * cur_h;
      end
    end

    drain_edges();
    if (edge_errors == 0) begin
      $display("** laplacian_edge_detect_3x3_top: PASSED **");
    end else begin
      $display("** laplacian_edge_detect_3x3_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lap3_pkg.sv
rtl/core/lap3_ram.sv
rtl/core/lap3_cell.sv
rtl/core/lap3_out_fifo.sv
rtl/core/laplacian_edge_detect_3x3_top.sv
bench/laplacian_edge_checker.sv
bench/laplacian_edge_detect_3x3_top_tb.sv
